// ----- rtl/tbct_pkg.sv -----
// shared types and constants of the ternary ball coverage tracker
package tbct_pkg;

    localparam int FIELD_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEC_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd2;

    // floor(t / 3) = (t * DIV3_MUL) >> DIV3_SHIFT, exact for t below 2**FIELD_W
    localparam int DIV3_SHIFT = FIELD_W + 1;
    localparam int DIV3_MUL   = (2 ** DIV3_SHIFT + 2) / 3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIGIT,
        ST_READ,
        ST_UPDATE,
        ST_HEAD,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic count;
        logic list;
        logic pos;
    } t_mem_we;

    typedef struct packed {
        logic [FIELD_W-1:0]  total;
        logic [FIELD_W-1:0]  first;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

// ----- rtl/tbct_ram.sv -----
// generic single-write, single-read memory with registered read data
module tbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 729
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tbct_ctrl.sv -----
// sequencer: walks the radius-1 ball and does the read-modify-write of counts, list and positions
module tbct_ctrl #(
    parameter int DIGITS = 6,
    parameter int WORDS  = 729
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic [tbct_pkg::FIELD_W-1:0] i_word,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output tbct_pkg::t_result           o_res,
    output tbct_pkg::t_mem_we           o_we,
    output logic [$clog2(WORDS)-1:0]    o_cnt_addr,
    output logic [tbct_pkg::COUNT_W-1:0] o_cnt_wdata,
    input  logic [tbct_pkg::COUNT_W-1:0] i_cnt_rdata,
    output logic [$clog2(WORDS)-1:0]    o_list_waddr,
    output logic [$clog2(WORDS)-1:0]    o_list_wdata,
    output logic [$clog2(WORDS)-1:0]    o_list_raddr,
    input  logic [$clog2(WORDS)-1:0]    i_list_rdata,
    output logic [$clog2(WORDS)-1:0]    o_pos_waddr,
    output logic [$clog2(WORDS)-1:0]    o_pos_wdata,
    output logic [$clog2(WORDS)-1:0]    o_pos_raddr,
    input  logic [$clog2(WORDS)-1:0]    i_pos_rdata
);
    import tbct_pkg::*;

    localparam int AW     = $clog2(WORDS);
    localparam int CW     = $clog2(WORDS + 1);
    localparam int SPACE  = 3 ** DIGITS;
    localparam int PW     = $clog2(SPACE + 1);
    localparam int MW     = ((PW > AW) ? PW : AW) + 2;
    localparam int DW     = $clog2(DIGITS + 1);
    localparam int PROD_W = FIELD_W + DIV3_SHIFT;

    localparam logic [CW-1:0] WORDS_C  = CW'(WORDS);
    localparam logic [MW-1:0] WORDS_M  = MW'(WORDS);
    localparam logic [AW-1:0] LAST_IDX = AW'(WORDS - 1);
    localparam logic [DW-1:0] TOP_DIG  = DW'(DIGITS - 1);

    // which member of the current digit is being visited
    localparam logic [1:0] STEP_SELF = 2'd0;
    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd2;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_func, n_func;
    logic [MW-1:0]      r_word, n_word;
    logic [FIELD_W-1:0] r_t, n_t;
    logic [1:0]         r_d, n_d;
    logic [PW-1:0]      r_p3, n_p3;
    logic [DW-1:0]      r_digit, n_digit;
    logic [1:0]         r_v, n_v;
    logic [CW-1:0]      r_size, n_size;
    logic [1:0]         r_status, n_status;

    logic [MW-1:0]        p3_m;
    logic [MW-1:0]        member;
    logic                 member_ok;
    logic [AW-1:0]        member_addr;
    logic [PROD_W-1:0]    prod;
    logic [FIELD_W-1:0]   quot;
    logic [FIELD_W+1:0]   three_q;
    logic [FIELD_W+1:0]   rem_full;
    logic [CW-1:0]        size_m1;
    logic                 in_range;
    logic                 members_done;
    logic                 pos_ok;
    logic                 last_ok;

    // member address from the word and the current digit
    assign p3_m = MW'(r_p3);

    always_comb begin
        case (r_v)
            STEP_SELF: member = r_word;
            STEP_UP:   member = (r_d < 2'd2) ? r_word + p3_m : r_word - (p3_m << 1);
            default:   member = (r_d == 2'd0) ? r_word + (p3_m << 1) : r_word - p3_m;
        endcase
    end

    assign member_ok   = member < WORDS_M;
    assign member_addr = member[AW-1:0];

    // one ternary digit per step by reciprocal multiply
    assign prod     = PROD_W'(r_t) * PROD_W'(DIV3_MUL);
    assign quot     = prod[DIV3_SHIFT +: FIELD_W];
    assign three_q  = {1'b0, quot, 1'b0} + {2'b00, quot};
    assign rem_full = {2'b00, r_t} - three_q;

    assign size_m1      = r_size - CW'(1);
    assign in_range     = MW'(i_word) < WORDS_M;
    assign members_done = (r_v == STEP_DOWN) && (r_digit == TOP_DIG);
    assign pos_ok       = CW'(i_pos_rdata) < WORDS_C;
    assign last_ok      = CW'(i_list_rdata) < WORDS_C;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = in_range ? ST_READ : ST_HEAD;
                end
            end
            ST_DIGIT:  n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (r_v == STEP_UP) begin
                    n_state = ST_READ;
                end else if (members_done) begin
                    n_state = ST_HEAD;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_HEAD:   n_state = ST_RESULT;
            ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_idx        = r_idx;
        n_func       = r_func;
        n_word       = r_word;
        n_t          = r_t;
        n_d          = r_d;
        n_p3         = r_p3;
        n_digit      = r_digit;
        n_v          = r_v;
        n_size       = r_size;
        n_status     = r_status;
        o_we         = '0;
        o_cnt_addr   = member_addr;
        o_cnt_wdata  = '0;
        o_list_waddr = '0;
        o_list_wdata = '0;
        o_list_raddr = '0;
        o_pos_waddr  = '0;
        o_pos_wdata  = '0;
        o_pos_raddr  = member_addr;

        unique case (r_state)
            ST_CLEAR: begin
                o_we         = '{count: 1'b1, list: 1'b1, pos: 1'b1};
                o_cnt_addr   = r_idx;
                o_list_waddr = r_idx;
                o_list_wdata = r_idx;
                o_pos_waddr  = r_idx;
                o_pos_wdata  = r_idx;
                n_idx        = r_idx + AW'(1);
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_func   = i_func;
                    n_word   = MW'(i_word);
                    n_t      = i_word;
                    n_p3     = PW'(1);
                    n_digit  = '0;
                    n_v      = STEP_SELF;
                    n_status = STATUS_OK;
                end
            end
            ST_DIGIT: begin
                n_t = quot;
                n_d = rem_full[1:0];
                n_v = STEP_UP;
            end
            ST_READ: begin
                // last list entry, needed if this member leaves the list
                o_list_raddr = size_m1[AW-1:0];
            end
            ST_UPDATE: begin
                if (member_ok) begin
                    if (!r_func) begin
                        if (i_cnt_rdata == COUNT_MAX) begin
                            n_status = STATUS_SAT;
                        end else begin
                            o_we.count  = 1'b1;
                            o_cnt_wdata = i_cnt_rdata + COUNT_W'(1);
                            // covered for the first time: swap-remove from the list
                            if (i_cnt_rdata == '0 && r_size != '0 && pos_ok) begin
                                n_size = size_m1;
                                if (last_ok) begin
                                    o_we.list    = 1'b1;
                                    o_we.pos     = 1'b1;
                                    o_list_waddr = i_pos_rdata;
                                    o_list_wdata = i_list_rdata;
                                    o_pos_waddr  = i_list_rdata;
                                    o_pos_wdata  = i_pos_rdata;
                                end
                            end
                        end
                    end else begin
                        if (i_cnt_rdata == '0) begin
                            n_status = STATUS_DEC_ZERO;
                        end else begin
                            o_we.count  = 1'b1;
                            o_cnt_wdata = i_cnt_rdata - COUNT_W'(1);
                            // uncovered again: append to the list
                            if (i_cnt_rdata == COUNT_W'(1) && r_size < WORDS_C) begin
                                o_we.list    = 1'b1;
                                o_we.pos     = 1'b1;
                                o_list_waddr = r_size[AW-1:0];
                                o_list_wdata = member_addr;
                                o_pos_waddr  = member_addr;
                                o_pos_wdata  = r_size[AW-1:0];
                                n_size       = r_size + CW'(1);
                            end
                        end
                    end
                end
                if (r_v == STEP_UP) begin
                    n_v = STEP_DOWN;
                end else if (r_v == STEP_DOWN) begin
                    n_p3    = r_p3 + (r_p3 << 1);
                    n_digit = r_digit + DW'(1);
                end
            end
            ST_HEAD:   o_list_raddr = '0;
            ST_RESULT: o_list_raddr = '0;
            default:   n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_size  <= WORDS_C;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_size  <= n_size;
        end
        r_func   <= n_func;
        r_word   <= n_word;
        r_t      <= n_t;
        r_d      <= n_d;
        r_p3     <= n_p3;
        r_digit  <= n_digit;
        r_v      <= n_v;
        r_status <= n_status;
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_res_valid  = (r_state == ST_RESULT);
    assign o_res.total  = FIELD_W'(r_size);
    assign o_res.first  = (r_size != '0) ? FIELD_W'(i_list_rdata) : '0;
    assign o_res.status = r_status;

endmodule

// ----- rtl/ternary_ball_coverage_tracker.sv -----
// Ternary ball coverage tracker: each transfer adds (func 0) or removes (func 1) one codeword
// and updates the coverage count of its 1 + 2*DIGITS ball members, keeping a swap-removal list
// of uncovered words. An in-range item visits each ball member with a read state and an update
// state for the read-modify-write of the count, list and position memories, and passes a digit
// state before each digit's two neighbours to split off that ternary digit; a head state then reads
// the list head and the result state offers it to the output register. An out-of-range word
// goes straight to the head and result states. After reset a clearing pass writes every memory
// address once, during which o_ready stays low.
// A finished result waits in an output register, so the next item is taken while it waits.
module ternary_ball_coverage_tracker #(
    parameter int DIGITS = 6,
    parameter int WORDS  = 729
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [tbct_pkg::FIELD_W-1:0]  i_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tbct_pkg::FIELD_W-1:0]  o_uncovered_total,
    output logic [tbct_pkg::FIELD_W-1:0]  o_first_uncovered,
    output logic [tbct_pkg::STATUS_W-1:0] o_status
);
    import tbct_pkg::*;

    localparam int AW = $clog2(WORDS);

    t_mem_we             we;
    t_result             res;
    logic                res_valid;
    logic                res_ready;
    logic [AW-1:0]       cnt_addr;
    logic [COUNT_W-1:0]  cnt_wdata;
    logic [COUNT_W-1:0]  cnt_rdata;
    logic [AW-1:0]       list_waddr;
    logic [AW-1:0]       list_wdata;
    logic [AW-1:0]       list_raddr;
    logic [AW-1:0]       list_rdata;
    logic [AW-1:0]       pos_waddr;
    logic [AW-1:0]       pos_wdata;
    logic [AW-1:0]       pos_raddr;
    logic [AW-1:0]       pos_rdata;

    logic                r_out_valid;
    t_result             r_out;

    tbct_ctrl #(
        .DIGITS (DIGITS),
        .WORDS  (WORDS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_word       (i_word),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_we         (we),
        .o_cnt_addr   (cnt_addr),
        .o_cnt_wdata  (cnt_wdata),
        .i_cnt_rdata  (cnt_rdata),
        .o_list_waddr (list_waddr),
        .o_list_wdata (list_wdata),
        .o_list_raddr (list_raddr),
        .i_list_rdata (list_rdata),
        .o_pos_waddr  (pos_waddr),
        .o_pos_wdata  (pos_wdata),
        .o_pos_raddr  (pos_raddr),
        .i_pos_rdata  (pos_rdata)
    );

    // coverage counts: read and written at the same member address
    tbct_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (WORDS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (we.count),
        .i_waddr (cnt_addr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_addr),
        .o_rdata (cnt_rdata)
    );

    tbct_ram #(
        .WIDTH (AW),
        .DEPTH (WORDS)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (we.list),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

    tbct_ram #(
        .WIDTH (AW),
        .DEPTH (WORDS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (we.pos),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // output register parts the sequencer from the consumer
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_uncovered_total = r_out.total;
    assign o_first_uncovered = r_out.first;
    assign o_status          = r_out.status;

endmodule

// ----- rtl/tbct_checker.sv -----
// port-level checks of the coverage tracker and their binding
module tbct_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [9:0] o_uncovered_total,
    input logic [9:0] o_first_uncovered,
    input logic [1:0] o_status
);

    // one item at a time: acceptance closes the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input still ready after a transfer");

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_ready)
        else $error("ready during memory clearing pass");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_uncovered_total == 10'd0)) |-> (o_first_uncovered == 10'd0))
        else $error("list head not zero with empty list");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_uncovered_total)
            && $stable(o_first_uncovered) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind ternary_ball_coverage_tracker tbct_checker u_tbct_checker (.*);

// ----- dv/tb_ternary_ball_coverage_tracker.sv -----
// self-checking testbench of the ternary ball coverage tracker
module tb_ternary_ball_coverage_tracker;
    import tbct_pkg::*;

    localparam int DIGITS   = 6;
    localparam int WORDS    = 729;
    localparam int SETTLE   = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_func;
    logic [FIELD_W-1:0]  i_word;
    logic                o_valid;
    logic                i_ready;
    logic [FIELD_W-1:0]  o_uncovered_total;
    logic [FIELD_W-1:0]  o_first_uncovered;
    logic [STATUS_W-1:0] o_status;

    ternary_ball_coverage_tracker #(
        .DIGITS (DIGITS),
        .WORDS  (WORDS)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_word            (i_word),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_uncovered_total (o_uncovered_total),
        .o_first_uncovered (o_first_uncovered),
        .o_status          (o_status)
    );

    class coverage_board;
        logic [COUNT_W-1:0] cover_cnt [WORDS];
        logic [FIELD_W-1:0] open_list [WORDS];
        logic [FIELD_W-1:0] open_pos  [WORDS];
        int                 open_size;
        t_result            pending_reports [$];
        int                 errors;

        function new();
            for (int i = 0; i < WORDS; i++) begin
                cover_cnt[i] = '0;
                open_list[i] = FIELD_W'(i);
                open_pos[i]  = FIELD_W'(i);
            end
            open_size = WORDS;
            errors    = 0;
        endfunction

        function void open_append(int w);
            if (open_size >= WORDS) return;
            open_pos[w]          = FIELD_W'(open_size);
            open_list[open_size] = FIELD_W'(w);
            open_size++;
        endfunction

        // swap the tail entry into the freed slot
        function void open_remove(int w);
            int p;
            int tail;
            if (open_size == 0) return;
            p = open_pos[w];
            open_size--;
            tail = open_list[open_size];
            open_list[p]   = FIELD_W'(tail);
            open_pos[tail] = FIELD_W'(p);
        endfunction

        function logic [STATUS_W-1:0] bump(int m, bit removing);
            if (!removing) begin
                if (cover_cnt[m] == COUNT_MAX) return STATUS_SAT;
                if (cover_cnt[m] == 0) open_remove(m);
                cover_cnt[m]++;
                return STATUS_OK;
            end
            if (cover_cnt[m] == 0) return STATUS_DEC_ZERO;
            cover_cnt[m]--;
            if (cover_cnt[m] == 0) open_append(m);
            return STATUS_OK;
        endfunction

        function void note_codeword(bit func, logic [FIELD_W-1:0] word);
            t_result             rep;
            logic [STATUS_W-1:0] st;
            logic [STATUS_W-1:0] s;
            int                  w;
            int                  t;
            int                  p3;
            int                  d;
            int                  m;
            st = STATUS_OK;
            w  = word;
            if (w < WORDS) begin
                s = bump(w, func);
                if (s != STATUS_OK) st = s;
                t  = w;
                p3 = 1;
                for (int i = 0; i < DIGITS; i++) begin
                    d = t % 3;
                    t = t / 3;
                    for (int v = 1; v <= 2; v++) begin
                        m = w - d * p3 + ((d + v) % 3) * p3;
                        s = bump(m, func);
                        if (s != STATUS_OK) st = s;
                    end
                    p3 = p3 * 3;
                end
            end
            rep.total  = FIELD_W'(open_size);
            rep.first  = (open_size != 0) ? open_list[0] : '0;
            rep.status = st;
            pending_reports.push_back(rep);
        endfunction

        function void check_report(logic [FIELD_W-1:0] total, logic [FIELD_W-1:0] first,
                                   logic [STATUS_W-1:0] status);
            t_result exp_rep;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result total %0d first %0d status %0d",
                         $time, total, first, status);
                errors++;
                return;
            end
            exp_rep = pending_reports.pop_front();
            if (total !== exp_rep.total) begin
                $display("%0t: uncovered_total expected %0d actual %0d",
                         $time, exp_rep.total, total);
                errors++;
            end
            if (first !== exp_rep.first) begin
                $display("%0t: first_uncovered expected %0d actual %0d",
                         $time, exp_rep.first, first);
                errors++;
            end
            if (status !== exp_rep.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_rep.status, status);
                errors++;
            end
        endfunction
    endclass

    coverage_board board = new();
    int            item_count;
    int            result_count;
    int            added_words [$];

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // every third stretch of 48 transfers runs without gaps
    function automatic int pick_gap(int n);
        if ((n / 48) % 3 == 2) return 0;
        return $urandom_range(0, 7);
    endfunction

    task automatic send_item(bit func, logic [FIELD_W-1:0] word);
        int gap;
        gap = pick_gap(item_count);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_func  = func;
        i_word  = word;
        do @(posedge i_clk); while (!o_ready);
        board.note_codeword(func, word);
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic random_item(int add_pct);
        int r;
        int k;
        logic [FIELD_W-1:0] w;
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
            w = FIELD_W'($urandom_range(0, WORDS - 1));
            added_words.push_back(w);
            send_item(1'b0, w);
        end else if (r < 95 && added_words.size() > 0) begin
            k = $urandom_range(0, added_words.size() - 1);
            w = FIELD_W'(added_words[k]);
            added_words.delete(k);
            send_item(1'b1, w);
        end else if (r % 2 == 0) begin
            // out of range codeword, state must stay put
            send_item(1'($urandom), FIELD_W'($urandom_range(WORDS, 1023)));
        end else begin
            send_item(1'b1, FIELD_W'($urandom_range(0, WORDS - 1)));
        end
    endtask

    // result side
    initial begin
        int gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = pick_gap(result_count);
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            result_count++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_report(o_uncovered_total, o_first_uncovered, o_status);
    end

    initial begin
        logic [FIELD_W-1:0] pile_word;
        int                 wait_cycles;
        item_count   = 0;
        result_count = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func  = 1'b0;
        i_word  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty-set removal, range edges, out of range words
        send_item(1'b1, 10'd0);
        send_item(1'b0, 10'd0);
        send_item(1'b0, 10'd728);
        send_item(1'b0, 10'd1023);
        send_item(1'b0, 10'd729);
        send_item(1'b1, 10'd729);
        send_item(1'b1, 10'd1023);
        send_item(1'b0, 10'd341);
        send_item(1'b0, 10'd682);
        send_item(1'b0, 10'd364);
        send_item(1'b1, 10'd0);
        send_item(1'b1, 10'd728);
        send_item(1'b1, 10'd0);
        send_item(1'b1, 10'd341);
        send_item(1'b1, 10'd682);
        send_item(1'b1, 10'd364);
        send_item(1'b1, 10'd364);

        // build up until every word is covered or 900 items are sent, then go on with mostly additions
        while (board.open_size > 0 && item_count < 900)
            random_item(85);
        repeat (40) random_item(90);

        // tear down
        repeat (450) random_item(15);

        // pile one codeword up to saturation and strip it below zero
        pile_word = FIELD_W'($urandom_range(0, WORDS - 1));
        repeat (258) send_item(1'b0, pile_word);
        repeat (260) send_item(1'b1, pile_word);

        while (item_count < 1570)
            random_item(55);

        i_valid = 1'b0;
        wait_cycles = 0;
        while (board.pending_reports.size() > 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (board.pending_reports.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.pending_reports.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
